[rtl/core/swm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the star wildcard matcher: item operation
// codes, the wildcard byte, and the control and status bundles of a cell.
// ----------------------------------------------------------------------------
package swm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_END     = 2'd3
    } op_t;

    localparam logic [7:0] STAR_CHAR = 8'h2A;

    // Broadcast from the top level to every cell for one accepted item.
    typedef struct packed {
        logic clear;
        logic append;
        logic advance;
        logic restart;
    } cell_ctl_t;

    // What a cell shows its neighbors and the match reduction.
    typedef struct packed {
        logic used;
        logic chain;
        logic lit;
        logic match;
    } cell_stat_t;

endpackage

[rtl/core/swm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One pattern position: holds the pattern byte, its used bit and its live bit,
// and passes star hand-offs and literal advances on to the next cell.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
#(
    parameter bit FIRST_CELL = 1'b0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctl_t  ctl,
    input  logic [7:0] character,
    input  logic       used_prev,
    input  logic       used_next,
    input  logic       chain_in,
    input  logic       lit_in,
    output cell_stat_t stat
);

    logic [7:0] pat_reg;
    logic [7:0] pat_next;
    logic       used_reg;
    logic       used_next_val;
    logic       live_reg;
    logic       live_next;
    logic       is_star;
    logic       eq_char;
    logic       active;

    assign is_star = (pat_reg == STAR_CHAR);
    assign eq_char = (pat_reg == character);

    // A star to the left hands the byte on when this position matches it,
    // so this position behaves as if live for the current byte.
    assign active = live_reg | (chain_in & used_reg & eq_char);

    assign stat.used  = used_reg;
    assign stat.chain = active & used_reg & is_star;
    assign stat.lit   = active & used_reg & ~is_star & eq_char;
    // Accept if this is the pattern end and live, or a live trailing star.
    assign stat.match = (live_reg & used_prev & ~used_reg)
                      | (live_reg & used_reg & is_star & ~used_next);

    always_comb
    begin
        pat_next      = pat_reg;
        used_next_val = used_reg;
        if (ctl.clear)
        begin
            used_next_val = 1'b0;
        end
        else if (ctl.append && used_prev && !used_reg)
        begin
            pat_next      = character;
            used_next_val = 1'b1;
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (ctl.restart)
        begin
            live_next = FIRST_CELL;
        end
        else if (ctl.advance)
        begin
            live_next = (active & used_reg & is_star) | lit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            live_reg <= FIRST_CELL;
        end
        else
        begin
            used_reg <= used_next_val;
            live_reg <= live_next;
        end
    end

endmodule

[rtl/core/swm_result_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_result_buffer
// Two-entry output buffer: an output register plus a skid register, so the
// cell row keeps taking items while a result waits to be taken.
// ----------------------------------------------------------------------------
module swm_result_buffer (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic push_matched,
    input  logic push_overflow,
    output logic full,
    output logic result_valid,
    input  logic result_stall,
    output logic matched,
    output logic pattern_overflow
);

    logic main_valid_reg;
    logic main_valid_next;
    logic main_matched_reg;
    logic main_matched_next;
    logic main_ovf_reg;
    logic main_ovf_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic skid_matched_reg;
    logic skid_matched_next;
    logic skid_ovf_reg;
    logic skid_ovf_next;
    logic main_free;

    assign main_free = !main_valid_reg || !result_stall;

    always_comb
    begin
        main_valid_next   = main_valid_reg;
        main_matched_next = main_matched_reg;
        main_ovf_next     = main_ovf_reg;
        skid_valid_next   = skid_valid_reg;
        skid_matched_next = skid_matched_reg;
        skid_ovf_next     = skid_ovf_reg;
        if (main_free)
        begin
            // A push never coincides with a full skid, since that stalls input.
            main_valid_next   = skid_valid_reg | push;
            main_matched_next = skid_valid_reg ? skid_matched_reg : push_matched;
            main_ovf_next     = skid_valid_reg ? skid_ovf_reg : push_overflow;
            skid_valid_next   = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next   = 1'b1;
            skid_matched_next = push_matched;
            skid_ovf_next     = push_overflow;
        end
    end

    always_ff @(posedge clk)
    begin
        main_matched_reg <= main_matched_next;
        main_ovf_reg     <= main_ovf_next;
        skid_matched_reg <= skid_matched_next;
        skid_ovf_reg     <= skid_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign full             = skid_valid_reg;
    assign result_valid     = main_valid_reg;
    assign matched          = main_matched_reg;
    assign pattern_overflow = main_ovf_reg;

endmodule

[rtl/core/star_wildcard_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_wildcard_matcher
// Glob matcher with '*' as its only wildcard, built as a row of position cells.
// ----------------------------------------------------------------------------
// Load a pattern with one clear item and then one append item per byte, stream
// the subject one byte per item, and send an end item to get one result with
// the match flag and the sticky overflow flag. Items may follow back to back
// when input is not stalled: each cell holds one pattern position with its
// live bit, and all positions update together, star hand-offs rippling along
// the row of PATTERN_MAX cells within the cycle. The block stalls input only
// when both the output register and the skid register hold results. Appends
// beyond PATTERN_MAX bytes are dropped and set the overflow flag, which forces
// matched low until the next clear.
module star_wildcard_matcher
    import swm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] operation,
    input  logic [7:0] character,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       matched,
    output logic       pattern_overflow
);

    cell_ctl_t              ctl;
    cell_stat_t             stat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] match_vec;
    logic                   accept;
    logic                   push;
    logic                   buf_full;
    logic                   end_live_reg;
    logic                   end_live_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   match_raw;

    assign accept     = item_valid && !buf_full;
    assign item_stall = buf_full;

    always_comb
    begin
        ctl  = '0;
        push = 1'b0;
        if (accept)
        begin
            unique case (op_t'(operation))
                OP_CLEAR:
                begin
                    ctl.clear   = 1'b1;
                    ctl.restart = 1'b1;
                end
                OP_APPEND:
                begin
                    ctl.append  = 1'b1;
                    ctl.restart = 1'b1;
                end
                OP_SUBJECT:
                begin
                    ctl.advance = 1'b1;
                end
                OP_END:
                begin
                    ctl.restart = 1'b1;
                    push        = 1'b1;
                end
                default:
                begin
                    ctl = '0;
                end
            endcase
        end
    end

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic used_prev;
        logic used_after;
        logic chain_in;
        logic lit_in;

        if (i == 0)
        begin : g_head
            assign used_prev = 1'b1;
            assign chain_in  = 1'b0;
            assign lit_in    = 1'b0;
        end
        else
        begin : g_body
            assign used_prev = stat[i-1].used;
            assign chain_in  = stat[i-1].chain;
            assign lit_in    = stat[i-1].lit;
        end

        if (i == PATTERN_MAX - 1)
        begin : g_tail
            assign used_after = 1'b0;
        end
        else
        begin : g_mid
            assign used_after = stat[i+1].used;
        end

        swm_cell #(
            .FIRST_CELL (i == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .character (character),
            .used_prev (used_prev),
            .used_next (used_after),
            .chain_in  (chain_in),
            .lit_in    (lit_in),
            .stat      (stat[i])
        );

        assign match_vec[i] = stat[i].match;
    end

    // The position past a full pattern has no cell of its own.
    always_comb
    begin
        end_live_next = end_live_reg;
        ovf_next      = ovf_reg;
        if (ctl.restart)
        begin
            end_live_next = 1'b0;
        end
        else if (ctl.advance)
        begin
            end_live_next = stat[PATTERN_MAX-1].lit;
        end
        if (ctl.clear)
        begin
            ovf_next = 1'b0;
        end
        else if (ctl.append && stat[PATTERN_MAX-1].used)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_live_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            end_live_reg <= end_live_next;
            ovf_reg      <= ovf_next;
        end
    end

    assign match_raw = (|match_vec) | (end_live_reg & stat[PATTERN_MAX-1].used);

    swm_result_buffer u_result_buffer (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .push_matched     (match_raw & ~ovf_reg),
        .push_overflow    (ovf_reg),
        .full             (buf_full),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

endmodule

[rtl/core/swm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the star wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker
    import swm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic [1:0] operation,
    input logic       result_valid,
    input logic       result_stall,
    input logic       matched,
    input logic       pattern_overflow
);

    // A waiting result keeps its value until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(matched)
            && $stable(pattern_overflow))
        else $error("stalled result changed");

    // Overflow forces the match flag low.
    a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(matched && pattern_overflow))
        else $error("match reported with overflow");

    // Input stalls only while a result is already on the output.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with empty output");

    // An end item meeting an empty or draining output shows a result next cycle.
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && operation == OP_END
            && !(result_valid && result_stall) |=> result_valid)
        else $error("end item gave no result");

endmodule

bind star_wildcard_matcher swm_checker u_swm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .operation        (operation),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the star wildcard matcher.
// ----------------------------------------------------------------------------
// Loads patterns, streams subjects and checks every end-of-subject verdict
// against a bit-level tracker of the live pattern positions. A short directed
// opening covers empty and single-star patterns, the byte extremes and the
// restart on append. Random sequences follow: mostly well-formed patterns with
// subjects derived from them, some full-length and overflowing patterns, and
// some noise and broken sequences. Both sides idle at random, and the receiver
// holds off once for a long stretch so the block fills up and stalls its input.
module tb;
    import swm_pkg::*;

    localparam int PATTERN_MAX   = 64;
    localparam int RANDOM_ITEMS  = 700;
    localparam int IDLE_LIMIT    = 5000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    typedef enum int {
        SEQ_NORMAL,
        SEQ_FULL,
        SEQ_OVERFLOW,
        SEQ_NOISE,
        SEQ_BROKEN
    } seq_kind_t;

    // Tracks the pattern, the live positions and the sticky overflow flag,
    // and keeps the verdicts that the block still owes.
    class glob_tracker;
        logic [7:0]  pattern_bytes [PATTERN_MAX];
        int unsigned pattern_len;
        bit          live [PATTERN_MAX + 1];
        bit          overflowed;
        verdict_t    pending_verdicts [$];
        int          mismatches;
        int          verdicts_checked;
        int          matches_seen;
        int          overflows_seen;
        int          op_count [4];

        function new();
            pattern_len = 0;
            overflowed  = 1'b0;
            mismatches  = 0;
            verdicts_checked = 0;
            matches_seen = 0;
            overflows_seen = 0;
            foreach (op_count[i]) op_count[i] = 0;
            restart_live();
        endfunction

        function void restart_live();
            foreach (live[i]) live[i] = 1'b0;
            live[0] = 1'b1;
        endfunction

        function void advance_positions(logic [7:0] ch);
            bit          upcoming [PATTERN_MAX + 1];
            int unsigned q;
            bit          done;
            foreach (upcoming[i]) upcoming[i] = 1'b0;
            for (int unsigned p = 0; p <= pattern_len; p++) begin
                if (live[p]) begin
                    q = p;
                    done = 1'b0;
                    // A star stays live and may pass the byte on to the next
                    // position, which then applies the same rule.
                    while (!done && q < pattern_len) begin
                        if (pattern_bytes[q] == STAR_CHAR) begin
                            upcoming[q] = 1'b1;
                            if (q + 1 < pattern_len && pattern_bytes[q + 1] == ch)
                                q++;
                            else
                                done = 1'b1;
                        end
                        else begin
                            if (pattern_bytes[q] == ch)
                                upcoming[q + 1] = 1'b1;
                            done = 1'b1;
                        end
                    end
                end
            end
            live = upcoming;
        endfunction

        function bit pattern_accepts();
            if (live[pattern_len])
                return 1'b1;
            return pattern_len > 0 && pattern_bytes[pattern_len - 1] == STAR_CHAR &&
                   live[pattern_len - 1];
        endfunction

        function void note_item(op_t op, logic [7:0] ch);
            verdict_t v;
            op_count[op]++;
            case (op)
                OP_CLEAR: begin
                    pattern_len = 0;
                    overflowed = 1'b0;
                    restart_live();
                end
                OP_APPEND: begin
                    if (pattern_len < PATTERN_MAX) begin
                        pattern_bytes[pattern_len] = ch;
                        pattern_len++;
                    end
                    else begin
                        overflowed = 1'b1;
                    end
                    restart_live();
                end
                OP_SUBJECT: advance_positions(ch);
                default: begin
                    v.overflow = overflowed;
                    v.matched  = pattern_accepts() && !overflowed;
                    pending_verdicts.push_back(v);
                    restart_live();
                end
            endcase
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH: %s", $time, what);
        endfunction

        function void check_result(logic got_matched, logic got_overflow);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result with none expected (matched=%b overflow=%b)",
                                 got_matched, got_overflow));
            end
            else begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (want.matched) matches_seen++;
                if (want.overflow) overflows_seen++;
                if (got_matched !== want.matched || got_overflow !== want.overflow)
                    report($sformatf("verdict %0d: expected matched=%b overflow=%b, got %b %b",
                                     verdicts_checked, want.matched, want.overflow,
                                     got_matched, got_overflow));
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic [1:0] operation = OP_CLEAR;
    logic [7:0] character = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       matched;
    logic       pattern_overflow;

    glob_tracker tracker;
    bit          steady = 1'b0;
    int          items_sent = 0;
    int          input_stall_cycles = 0;
    logic [7:0]  sent_pattern [$];

    star_wildcard_matcher #(
        .PATTERN_MAX(PATTERN_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .operation(operation),
        .character(character),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .matched(matched),
        .pattern_overflow(pattern_overflow)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Results are checked before the item of the same edge is noted, since a
    // result leaving now always belongs to an earlier item.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (result_valid && !result_stall)
                tracker.check_result(matched, pattern_overflow);
            if (item_valid && !item_stall)
                tracker.note_item(op_t'(operation), character);
            if (item_valid && item_stall)
                input_stall_cycles++;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random hold-offs, plus one long hold that backs the block up.
    initial
    begin : receiver
        int wait_cycles;
        int taken;
        taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (taken == 20) begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else begin
                wait_cycles = steady ? 0 : $urandom_range(0, 10);
                if (wait_cycles > 0) begin
                    result_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            taken++;
        end
    end

    task automatic send_item(input op_t op, input logic [7:0] ch);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        operation <= op;
        character <= ch;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    // Mostly a small alphabet with stars so that matches happen, sometimes any byte.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return "a";
        if (r < 6) return "b";
        if (r < 8) return STAR_CHAR;
        if (r < 9) return "c";
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pattern(input int len, input bit with_clear);
        logic [7:0] ch;
        if (with_clear)
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
        sent_pattern.delete();
        repeat (len) begin
            ch = pick_char();
            sent_pattern.push_back(ch);
            send_item(OP_APPEND, ch);
        end
    endtask

    // Builds a subject that fits the last pattern, then sometimes spoils it.
    task automatic send_subject();
        logic [7:0] subj [$];
        foreach (sent_pattern[i]) begin
            if (sent_pattern[i] == STAR_CHAR)
                repeat ($urandom_range(0, 3)) subj.push_back(pick_char());
            else
                subj.push_back(sent_pattern[i]);
        end
        case ($urandom_range(0, 5))
            0: if (subj.size() > 0) subj[$urandom_range(0, subj.size() - 1)] = pick_char();
            1: if (subj.size() > 0) void'(subj.pop_back());
            2: subj.push_back(pick_char());
            default: ;
        endcase
        foreach (subj[i]) send_item(OP_SUBJECT, subj[i]);
        send_item(OP_END, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin : stimulus
        int        directed_items;
        int        seq_index;
        seq_kind_t kind;
        int        r;
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pattern and empty subject straight out of reset.
        send_item(OP_END, 8'h00);
        // A lone star matches the empty subject and anything else.
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_APPEND, STAR_CHAR);
        send_item(OP_END, 8'hFF);
        send_item(OP_SUBJECT, 8'h00);
        send_item(OP_END, 8'h00);
        // The byte extremes are plain literals.
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_APPEND, 8'h00);
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_SUBJECT, 8'h00);
        send_item(OP_SUBJECT, 8'hFF);
        send_item(OP_END, 8'h55);
        send_item(OP_SUBJECT, 8'hFF);
        send_item(OP_END, 8'hAA);
        // Stars between literals; an append in between restarts the subject.
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_APPEND, "a");
        send_item(OP_APPEND, STAR_CHAR);
        send_item(OP_APPEND, "b");
        send_item(OP_APPEND, STAR_CHAR);
        send_item(OP_SUBJECT, "a");
        send_item(OP_SUBJECT, "b");
        send_item(OP_SUBJECT, "b");
        send_item(OP_END, 8'h00);
        send_item(OP_APPEND, "c");
        send_item(OP_END, 8'h00);
        directed_items = items_sent;

        seq_index = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                steady = !steady;
            r = $urandom_range(0, 19);
            kind = r < 14 ? SEQ_NORMAL : (r < 17 ? SEQ_NOISE : SEQ_BROKEN);
            if (seq_index == 4 || seq_index == 30)
                kind = SEQ_FULL;
            if (seq_index == 12)
                kind = SEQ_OVERFLOW;
            seq_index++;
            case (kind)
                SEQ_NORMAL: begin
                    send_pattern($urandom_range(0, 8), $urandom_range(0, 4) != 0);
                    repeat ($urandom_range(1, 3)) send_subject();
                end
                SEQ_FULL: begin
                    send_pattern(seq_index == 5 ? PATTERN_MAX : $urandom_range(56, PATTERN_MAX),
                                 1'b1);
                    repeat (2) send_subject();
                end
                SEQ_OVERFLOW: begin
                    send_pattern($urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 6), 1'b1);
                    send_subject();
                    // The flag stays set until a clear.
                    send_item(OP_APPEND, pick_char());
                    send_item(OP_END, 8'h00);
                end
                SEQ_NOISE: begin
                    repeat ($urandom_range(1, 6))
                        send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
                default: begin
                    repeat ($urandom_range(0, 4)) send_item(OP_SUBJECT, pick_char());
                    send_item(OP_APPEND, pick_char());
                    repeat ($urandom_range(0, 3)) send_item(OP_SUBJECT, pick_char());
                    send_item(OP_END, 8'($urandom_range(0, 255)));
                end
            endcase
        end
        send_item(OP_END, 8'h00);
        item_valid <= 1'b0;

        while (tracker.pending_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.pending_verdicts.size() > 0) begin
            $display("%0d expected verdicts never arrived", tracker.pending_verdicts.size());
            tracker.mismatches += tracker.pending_verdicts.size();
        end
        $display("Sent %0d items: %0d clears, %0d appends, %0d subject bytes, %0d ends.",
                 items_sent, tracker.op_count[OP_CLEAR], tracker.op_count[OP_APPEND],
                 tracker.op_count[OP_SUBJECT], tracker.op_count[OP_END]);
        $display("Checked %0d verdicts (%0d matches, %0d overflowed); input stalled %0d cycles.",
                 tracker.verdicts_checked, tracker.matches_seen, tracker.overflows_seen,
                 input_stall_cycles);
        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
